// File: src/lm3_pkg.sv
// Shared types and constants for the 3x3 local-maximum detector.
// Used by the column cell, the line memory and the top level; no dependencies.
`default_nettype none

package lm3_pkg;

  // pixel and geometry widths
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned ADDR_W    = $clog2(MAX_WIDTH);
  localparam int unsigned WIDTH_W   = 11;
  localparam int unsigned HEIGHT_W  = 16;
  localparam int unsigned COL_W     = 10;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

  // configuration reset values and geometry minimums
  localparam logic [PIX_W-1:0]    THRESHOLD_RST = 16'd1;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST     = 11'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST    = 16'd1024;
  localparam logic [WIDTH_W-1:0]  WIDTH_MIN     = 11'd3;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN    = 16'd3;

  typedef logic signed [PIX_W-1:0] pix_t;

  // one window column, top row to bottom row
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } column_t;

endpackage

`default_nettype wire

// File: src/local_maxima_3x3_threshold.sv
// Top level of the 3x3 thresholded local-maximum detector.
// Depends on lm3_pkg, lm3_line_mem and lm3_col_cell.
//
//  channel   dir   handshake             payload
//  s_axis    in    tvalid/tready         tdata = pixel
//  m_axis    out   tvalid/tready         tdata = col, row; tuser = is_max; tlast = frame_last
//  cfg       in    cfg_we_i              cfg_idx_i, cfg_data_i
//
// One pixel per clock sustained while m_axis does not stall; a result reaches m_axis
// through three registers after the edge that accepts its last pixel: the
// registered line-memory read, the window cell stage and the output register.
// Reset clears counters and stage valids and loads the configuration reset values;
// the line memory needs no clearing pass. A stall on m_axis holds all stages and drops s_axis_tready.
`default_nettype none

module local_maxima_3x3_threshold (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // pixel input
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [15:0]                       s_axis_tdata,   // [15:0] pixel
  // result output
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [31:0]                            m_axis_tdata,   // [9:0] col, [25:10] row
  output logic                                   m_axis_tuser,   // [0] is_max
  output logic                                   m_axis_tlast,   // frame_last
  // configuration writes
  input  wire logic                              cfg_we_i,
  input  wire logic [lm3_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [15:0]                       cfg_data_i
);

  // ---------------- configuration ----------------
  logic signed [lm3_pkg::PIX_W-1:0]  thr_q;
  logic [lm3_pkg::WIDTH_W-1:0]       width_q;
  logic [lm3_pkg::HEIGHT_W-1:0]      height_q;
  logic [lm3_pkg::WIDTH_W-1:0]       w_eff;
  logic [lm3_pkg::HEIGHT_W-1:0]      h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= lm3_pkg::THRESHOLD_RST;
      width_q  <= lm3_pkg::WIDTH_RST;
      height_q <= lm3_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lm3_pkg::CFG_THRESHOLD: thr_q    <= cfg_data_i;
        lm3_pkg::CFG_WIDTH:     width_q  <= cfg_data_i[lm3_pkg::WIDTH_W-1:0];
        lm3_pkg::CFG_HEIGHT:    height_q <= cfg_data_i[lm3_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp geometry to the supported range
  always_comb begin
    if (width_q < lm3_pkg::WIDTH_MIN) begin
      w_eff = lm3_pkg::WIDTH_MIN;
    end else if (width_q > lm3_pkg::WIDTH_W'(lm3_pkg::MAX_WIDTH)) begin
      w_eff = lm3_pkg::WIDTH_W'(lm3_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    h_eff = (height_q < lm3_pkg::HEIGHT_MIN) ? lm3_pkg::HEIGHT_MIN : height_q;
  end

  // ---------------- handshake ----------------
  logic adv;
  logic s_fire;
  logic m_valid_q;

  assign adv           = !m_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign s_fire        = s_axis_tvalid && adv;

  // ---------------- position counters ----------------
  logic [lm3_pkg::COL_W-1:0]    col_q, col_d;
  logic [lm3_pkg::HEIGHT_W-1:0] row_q, row_d;
  logic [lm3_pkg::COL_W-1:0]    cur_c;
  logic [lm3_pkg::HEIGHT_W-1:0] cur_r;
  logic [lm3_pkg::HEIGHT_W:0]   row_pre;
  logic [lm3_pkg::WIDTH_W-1:0]  c_inc;
  logic [lm3_pkg::HEIGHT_W:0]   r_inc;

  // wrap a counter left beyond a new geometry, then step to the next pixel
  always_comb begin
    if ({1'b0, col_q} >= w_eff) begin
      cur_c   = '0;
      row_pre = {1'b0, row_q} + 1'b1;
    end else begin
      cur_c   = col_q;
      row_pre = {1'b0, row_q};
    end
    cur_r = (row_pre >= {1'b0, h_eff}) ? '0 : row_pre[lm3_pkg::HEIGHT_W-1:0];

    c_inc = {1'b0, cur_c} + 1'b1;
    r_inc = {1'b0, cur_r} + 1'b1;
    if (c_inc >= w_eff) begin
      col_d = '0;
      row_d = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[lm3_pkg::HEIGHT_W-1:0];
    end else begin
      col_d = c_inc[lm3_pkg::COL_W-1:0];
      row_d = cur_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (s_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------- stage 1: line read in flight ----------------
  logic                          s1_valid_q;
  lm3_pkg::pix_t                 s1_px_q;
  logic [lm3_pkg::ADDR_W-1:0]    s1_addr_q;
  logic                          s1_emit_q;
  logic                          s1_last_q;
  logic [lm3_pkg::COL_W-1:0]     s1_oc_q;
  logic [lm3_pkg::HEIGHT_W-1:0]  s1_or_q;
  logic [2*lm3_pkg::PIX_W-1:0]   line_rd;
  logic                          line_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_px_q   <= s_axis_tdata;
      s1_addr_q <= cur_c[lm3_pkg::ADDR_W-1:0];
      s1_emit_q <= (cur_c >= lm3_pkg::COL_W'(2)) && (cur_r >= lm3_pkg::HEIGHT_W'(2));
      s1_last_q <= ({1'b0, cur_c} == (w_eff - 1'b1)) && (cur_r == (h_eff - 1'b1));
      s1_oc_q   <= cur_c - 1'b1;
      s1_or_q   <= cur_r - 1'b1;
    end
  end

  // middle row moves to upper, new pixel becomes middle
  assign line_we = adv && s1_valid_q;

  lm3_line_mem u_line_mem (
    .clk_i   (clk_i),
    .re_i    (s_fire),
    .raddr_i (cur_c[lm3_pkg::ADDR_W-1:0]),
    .rdata_o (line_rd),
    .we_i    (line_we),
    .waddr_i (s1_addr_q),
    .wdata_i ({line_rd[lm3_pkg::PIX_W-1:0], s1_px_q})
  );

  // ---------------- stage 2: window cell chain ----------------
  lm3_pkg::column_t              new_col;
  lm3_pkg::column_t              chain [4];
  logic [2:0]                    gt;
  lm3_pkg::pix_t                 ctr;
  logic                          s2_valid_q;
  logic                          s2_emit_q;
  logic                          s2_last_q;
  logic [lm3_pkg::COL_W-1:0]     s2_oc_q;
  logic [lm3_pkg::HEIGHT_W-1:0]  s2_or_q;

  // upper word holds the row two above, lower word the row above
  assign new_col.top = line_rd[2*lm3_pkg::PIX_W-1:lm3_pkg::PIX_W];
  assign new_col.mid = line_rd[lm3_pkg::PIX_W-1:0];
  assign new_col.bot = s1_px_q;
  assign chain[0]    = new_col;
  assign ctr         = chain[2].mid;

  for (genvar k = 0; k < 3; k++) begin : g_cell
    lm3_col_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (line_we),
      .col_i      (chain[k]),
      .ctr_i      (ctr),
      .skip_mid_i (k == 1),
      .col_o      (chain[k+1]),
      .gt_o       (gt[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_we) begin
      s2_emit_q <= s1_emit_q;
      s2_last_q <= s1_last_q;
      s2_oc_q   <= s1_oc_q;
      s2_or_q   <= s1_or_q;
    end
  end

  // ---------------- stage 3: output register ----------------
  logic                          m_max_q;
  logic                          m_last_q;
  logic [lm3_pkg::COL_W-1:0]     m_col_q;
  logic [lm3_pkg::HEIGHT_W-1:0]  m_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= s2_valid_q && s2_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_max_q  <= (ctr > thr_q) && (&gt);
      m_last_q <= s2_last_q;
      m_col_q  <= s2_oc_q;
      m_row_q  <= s2_or_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, m_row_q, m_col_q};
  assign m_axis_tuser  = m_max_q;
  assign m_axis_tlast  = m_last_q;

  // ---------------- checks ----------------
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> ({1'b0, col_q} < $past(w_eff)))
    else $error("column counter left the image width");

  a_no_addr_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_we && s_fire) |-> (cur_c[lm3_pkg::ADDR_W-1:0] != s1_addr_q))
    else $error("line memory read and write hit the same column");

  a_interior_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> ((m_col_q != '0) && (m_row_q != '0)))
    else $error("result for a border pixel");

  a_out_from_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(s2_valid_q))
    else $error("result without a window in stage 2");

endmodule

`default_nettype wire

// File: src/lm3_line_mem.sv
// Line store for the two previous rows, one word per column {upper, middle}.
// Single write port, single registered read port; uses lm3_pkg.
`default_nettype none

module lm3_line_mem (
  input  wire logic                         clk_i,
  input  wire logic                         re_i,
  input  wire logic [lm3_pkg::ADDR_W-1:0]   raddr_i,
  output logic      [2*lm3_pkg::PIX_W-1:0]  rdata_o,
  input  wire logic                         we_i,
  input  wire logic [lm3_pkg::ADDR_W-1:0]   waddr_i,
  input  wire logic [2*lm3_pkg::PIX_W-1:0]  wdata_i
);

  logic [2*lm3_pkg::PIX_W-1:0] mem [lm3_pkg::MAX_WIDTH];
  logic [2*lm3_pkg::PIX_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/lm3_col_cell.sv
// One column cell of the 3x3 window: holds a column and passes it on.
// Also flags whether the window center beats all pixels it holds but itself; uses lm3_pkg.
`default_nettype none

module lm3_col_cell (
  input  wire logic             clk_i,
  input  wire logic             shift_i,
  input  wire lm3_pkg::column_t col_i,
  input  wire lm3_pkg::pix_t    ctr_i,
  input  wire logic             skip_mid_i,
  output lm3_pkg::column_t      col_o,
  output logic                  gt_o
);

  lm3_pkg::column_t col_q;

  // column register, loads on each window shift
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  // center strictly greater than held pixels; the center itself is skipped
  always_comb begin
    gt_o = (ctr_i > col_q.top) && (ctr_i > col_q.bot) && (skip_mid_i || (ctr_i > col_q.mid));
  end

  assign col_o = col_q;

endmodule

`default_nettype wire

// File: tb/tb.sv
// Testbench for local_maxima_3x3_threshold: streams raster frames, predicts each 3x3 result
// and checks every output transaction in order. Depends on lm3_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb;

  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT  = 1000000;

  // one expected result: interior pixel position and its flags
  typedef struct packed {
    logic [lm3_pkg::COL_W-1:0]    col;
    logic [lm3_pkg::HEIGHT_W-1:0] row;
    logic                         is_max;
    logic                         frame_last;
  } peak_t;

  logic                          clk_i    = 1'b0;
  logic                          rst_ni   = 1'b0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [15:0]                   s_tdata  = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [31:0]                   m_tdata;
  logic                          m_tuser;
  logic                          m_tlast;
  logic                          cfg_we   = 1'b0;
  logic [lm3_pkg::CFG_IDX_W-1:0] cfg_idx  = lm3_pkg::CFG_THRESHOLD;
  logic [15:0]                   cfg_data = '0;

  // predictor copy of line stores, window and position
  lm3_pkg::pix_t                upper_line [lm3_pkg::MAX_WIDTH] = '{default: '0};
  lm3_pkg::pix_t                middle_line [lm3_pkg::MAX_WIDTH] = '{default: '0};
  lm3_pkg::pix_t                win [6] = '{default: '0};
  int unsigned                  col_cnt = 0;
  int unsigned                  row_cnt = 0;
  lm3_pkg::pix_t                thr = lm3_pkg::pix_t'(lm3_pkg::THRESHOLD_RST);
  logic [lm3_pkg::WIDTH_W-1:0]  cfg_width = lm3_pkg::WIDTH_RST;
  logic [lm3_pkg::HEIGHT_W-1:0] cfg_height = lm3_pkg::HEIGHT_RST;

  peak_t peak_q[$];
  int    errors = 0;
  int    items_sent = 0;
  int    src_idle_pct = 0;
  int    snk_stall_pct = 0;
  bit    hold_req = 1'b0;
  int    hold_left = 0;
  int    cycle_cnt = 0;

  local_maxima_3x3_threshold dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),   // [15:0] pixel
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),   // [9:0] col, [25:10] row
    .m_axis_tuser  (m_tuser),   // [0] is_max
    .m_axis_tlast  (m_tlast),   // frame_last
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // one pixel through the window: updates stores, queues a result for interior pixels
  function automatic void advance_window(input lm3_pkg::pix_t px);
    int unsigned   w, h, c, r, idx;
    lm3_pkg::pix_t top, mid, ctr;
    lm3_pkg::pix_t nb [8];
    logic          mx;
    peak_t         pk;
    w = (cfg_width < lm3_pkg::WIDTH_MIN) ? lm3_pkg::WIDTH_MIN :
        ((cfg_width > lm3_pkg::MAX_WIDTH) ? lm3_pkg::MAX_WIDTH : cfg_width);
    h = (cfg_height < lm3_pkg::HEIGHT_MIN) ? lm3_pkg::HEIGHT_MIN : cfg_height;
    // a shrunk geometry wraps a counter that is out of range
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    c = col_cnt;
    r = row_cnt;
    idx = c % lm3_pkg::MAX_WIDTH;
    top = upper_line[idx];
    mid = middle_line[idx];
    upper_line[idx] = mid;
    middle_line[idx] = px;
    if (c >= 2 && r >= 2) begin
      ctr = win[4];
      nb = '{win[0], win[1], win[2], win[3], win[5], top, mid, px};
      mx = (ctr > thr);
      foreach (nb[k]) if (!(ctr > nb[k])) mx = 1'b0;
      pk.col = lm3_pkg::COL_W'(c - 1);
      pk.row = lm3_pkg::HEIGHT_W'(r - 1);
      pk.is_max = mx;
      pk.frame_last = (c == w - 1) && (r == h - 1);
      peak_q.push_back(pk);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = px;
    col_cnt = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = r + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    peak_t want;
    if (m_tvalid && m_tready) begin
      if (peak_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got col %0d row %0d", $time,
                 m_tdata[9:0], m_tdata[25:10]);
        errors++;
      end else begin
        want = peak_q.pop_front();
        check_field("col", want.col, m_tdata[9:0]);
        check_field("row", want.row, m_tdata[25:10]);
        check_field("tdata padding", 0, m_tdata[31:26]);
        check_field("is_max", want.is_max, m_tuser);
        check_field("frame_last", want.frame_last, m_tlast);
      end
    end
  end

  // receiver: random stalls, or a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  function automatic lm3_pkg::pix_t rand_pixel();
    case ($urandom_range(3))
      0: return lm3_pkg::pix_t'($urandom);
      1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return lm3_pkg::pix_t'($urandom_range(8)) - lm3_pkg::pix_t'(4);
    endcase
  endfunction

  task automatic set_idling(input int src, input int snk);
    src_idle_pct = src;
    snk_stall_pct = snk;
  endtask

  // one pixel transaction; called and returns at a falling edge
  task automatic push_pixel(input lm3_pkg::pix_t px);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= px;
    do @(posedge clk_i); while (!s_tready);
    advance_window(px);
    items_sent++;
    @(negedge clk_i);
  endtask

  // no input offered, all results in, pipeline empty
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (peak_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [lm3_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      lm3_pkg::CFG_THRESHOLD: thr = lm3_pkg::pix_t'(val);
      lm3_pkg::CFG_WIDTH:     cfg_width = val[lm3_pkg::WIDTH_W-1:0];
      lm3_pkg::CFG_HEIGHT:    cfg_height = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic finish_frame();
    while (col_cnt != 0 || row_cnt != 0) push_pixel(rand_pixel());
  endtask

  // 5x5 frame: extreme values, corner neighbor blocking, ties, above-threshold peak
  task automatic test_window_cases();
    lm3_pkg::pix_t img [25];
    img = '{-32768,     0,  0,   0, 32767,
                 0, 32767,  0, 101,     0,
                 0,     0, -5,   0,     0,
               200,   300, 100, 300,  200,
                -1,    50, 50,  50,   300};
    set_idling(0, 0);
    write_reg(lm3_pkg::CFG_THRESHOLD, 16'd100);
    write_reg(lm3_pkg::CFG_WIDTH, 16'd5);
    write_reg(lm3_pkg::CFG_HEIGHT, 16'd5);
    foreach (img[i]) push_pixel(img[i]);
    wait_idle();
  endtask

  // sizes below the minimum are used as 3x3; center at and above threshold
  task automatic test_size_clamps();
    set_idling(34, 34);
    // center equal to the top threshold: not a maximum
    write_reg(lm3_pkg::CFG_THRESHOLD, 16'h7fff);
    write_reg(lm3_pkg::CFG_WIDTH, 16'd2);
    write_reg(lm3_pkg::CFG_HEIGHT, 16'd0);
    for (int i = 0; i < 9; i++) push_pixel((i == 4) ? 16'sh7fff : 16'sh0000);
    wait_idle();
    // lowest threshold, center just above a flat floor
    write_reg(lm3_pkg::CFG_THRESHOLD, 16'h8000);
    write_reg(lm3_pkg::CFG_WIDTH, 16'd0);
    write_reg(lm3_pkg::CFG_HEIGHT, 16'd1);
    for (int i = 0; i < 9; i++) push_pixel((i == 4) ? 16'sh8001 : 16'sh8000);
    wait_idle();
    write_reg(lm3_pkg::CFG_THRESHOLD, 16'd5);
    write_reg(lm3_pkg::CFG_WIDTH, 16'd1);
    write_reg(lm3_pkg::CFG_HEIGHT, 16'd2);
    for (int i = 0; i < 9; i++) push_pixel((i == 4) ? 16'sd6 : 16'sd5);
    wait_idle();
  endtask

  // geometry shrunk while counters are inside the frame, then a very tall frame cut short
  task automatic test_midframe_geometry();
    set_idling(60, 0);
    write_reg(lm3_pkg::CFG_THRESHOLD, 16'd0);
    write_reg(lm3_pkg::CFG_WIDTH, 16'd12);
    write_reg(lm3_pkg::CFG_HEIGHT, 16'd6);
    repeat (32) push_pixel(rand_pixel());
    wait_idle();
    write_reg(lm3_pkg::CFG_WIDTH, 16'd4);    // column 8 is beyond the new width
    repeat (10) push_pixel(rand_pixel());
    wait_idle();
    write_reg(lm3_pkg::CFG_HEIGHT, 16'hffff);
    repeat (22) push_pixel(rand_pixel());
    wait_idle();
    write_reg(lm3_pkg::CFG_HEIGHT, 16'd3);   // row now beyond the new height
    finish_frame();
    // wider again only from the frame start
    wait_idle();
    write_reg(lm3_pkg::CFG_WIDTH, 16'd9);
    write_reg(lm3_pkg::CFG_HEIGHT, 16'd4);
    finish_frame();
    repeat (36) push_pixel(rand_pixel());
    wait_idle();
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    set_idling(0, 0);
    write_reg(lm3_pkg::CFG_THRESHOLD, 16'd1);
    write_reg(lm3_pkg::CFG_WIDTH, 16'd16);
    write_reg(lm3_pkg::CFG_HEIGHT, 16'd12);
    hold_req = 1'b1;
    repeat (150) push_pixel(rand_pixel());
    finish_frame();
    wait_idle();
  endtask

  // whole frames of random size and content across the idling phases
  task automatic test_random_frames();
    int          start;
    int unsigned w, h;
    logic [15:0] thr_word;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      case ((items_sent - start) * 4 / RANDOM_ITEMS)
        0: set_idling(0, 0);
        1: set_idling(60, 0);
        2: set_idling(0, 60);
        default: set_idling(34, 34);
      endcase
      w = ($urandom_range(7) == 0) ? $urandom_range(13, 48) : $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      case ($urandom_range(7))
        0: thr_word = 16'h8000;
        1: thr_word = 16'h7fff;
        2: thr_word = 16'($urandom);
        default: thr_word = 16'($urandom_range(6)) - 16'd3;
      endcase
      wait_idle();
      write_reg(lm3_pkg::CFG_THRESHOLD, thr_word);
      // bits above the width field are ignored by the block
      write_reg(lm3_pkg::CFG_WIDTH, {5'($urandom), 11'(w)});
      write_reg(lm3_pkg::CFG_HEIGHT, 16'(h));
      do push_pixel(rand_pixel()); while (col_cnt != 0 || row_cnt != 0);
    end
    wait_idle();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_window_cases();
    test_size_clamps();
    test_midframe_geometry();
    test_backpressure();
    test_random_frames();
    wait_idle();
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
